>>> rtl/particle_pool_engine_macros.svh
// Assertion macros shared by the particle pool engine modules.
`ifndef PARTICLE_POOL_ENGINE_MACROS_SVH
`define PARTICLE_POOL_ENGINE_MACROS_SVH
`ifndef SYNTH
`define PPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPE_ASSERT_IMP(lbl, ante, cons, msg)
`define PPE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/ppe_pkg.sv
// Package with the types, constants and helpers of the particle pool engine.
package ppe_pkg;

    localparam int POOL_SLOTS = 64;
    localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CFG_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMITTER_X   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMITTER_Y   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EMITTER_Z   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_LIFE  = 4'd7;

    localparam logic signed [31:0] EMITTER_Z_RST  = -32'sd1310720;
    localparam logic signed [31:0] GRAVITY_RST    = -32'sd642908;
    localparam logic [30:0]        SPAWN_LIFE_RST = 31'd327680;

    localparam logic KIND_SPAWN = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRAV,
        ST_SP_SCAN,
        ST_SP_WRITE,
        ST_TK_SCAN,
        ST_TK_LOAD,
        ST_TK_MUL,
        ST_TK_POS,
        ST_TK_WB,
        ST_D_DIFF,
        ST_D_SQ,
        ST_D_SUM,
        ST_PUSH,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic grav;
        logic step;
        logic sp_take;
        logic sp_write;
        logic tk_load;
        logic tk_mul;
        logic tk_pos;
        logic tk_wb;
        logic d_diff;
        logic d_sq;
        logic d_sum;
        logic push;
        logic flush;
    } ctl_t;

    typedef struct packed {
        logic kind;
        logic free_hit;
        logic act_hit;
        logic scan_end;
        logic idx_end;
        logic life_pos;
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

>>> rtl/particle_pool_engine.sv
// Particle pool engine top level: controller, datapath and configuration port.
// A spawn gives a single result word; its free-slot scan checks one slot a cycle,
// starting from the last used slot.
// In a tick, the scan checks one slot a cycle until it meets an active slot; each slot that
// stays alive runs the update and distance steps in turn, and one that dies skips them.
// Reset clears the life flags of all slots to dead at once; no clearing pass is needed.
`include "particle_pool_engine_macros.svh"
module particle_pool_engine
    import ppe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [15:0]           delta_time,
    input  logic signed [31:0]    vel_x,
    input  logic signed [31:0]    vel_y,
    input  logic signed [31:0]    vel_z,
    input  logic [31:0]           color_rgba,
    input  logic [15:0]           particle_size,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data,
    output logic                  result_valid,
    output logic [SLOT_W-1:0]     slot,
    output logic signed [31:0]    pos_x,
    output logic signed [31:0]    pos_y,
    output logic signed [31:0]    pos_z,
    output logic [15:0]           size_out,
    output logic [31:0]           color_out,
    output logic [63:0]           distance_sq,
    output logic                  alive,
    output logic                  last
);

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    ppe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    ppe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .delta_time    (delta_time),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .vel_z         (vel_z),
        .color_rgba    (color_rgba),
        .particle_size (particle_size),
        .ctl           (ctl),
        .sts           (sts),
        .result_valid  (result_valid),
        .slot          (slot),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .size_out      (size_out),
        .color_out     (color_out),
        .distance_sq   (distance_sq),
        .alive         (alive),
        .last          (last)
    );

    `PPE_ASSERT_IMP(a_cfg_idle, cfg_valid, !busy, "configuration write while busy")

endmodule

>>> rtl/ppe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ppe_ctrl.sv
// Controller state machine of the particle pool engine.
`include "particle_pool_engine_macros.svh"
module ppe_ctrl
    import ppe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic kind,
    output logic busy,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = (kind == KIND_TICK) ? ST_GRAV : ST_SP_SCAN;
                end
            end
            ST_GRAV:
            begin
                ctl.grav   = 1'b1;
                state_next = ST_TK_SCAN;
            end
            ST_SP_SCAN:
            begin
                if (sts.free_hit || sts.scan_end)
                begin
                    ctl.sp_take = 1'b1;
                    state_next  = ST_SP_WRITE;
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            ST_SP_WRITE:
            begin
                ctl.sp_write = 1'b1;
                state_next   = ST_D_DIFF;
            end
            ST_TK_SCAN:
            begin
                if (sts.act_hit)
                begin
                    state_next = ST_TK_LOAD;
                end
                else if (sts.idx_end)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            ST_TK_LOAD:
            begin
                ctl.tk_load = 1'b1;
                state_next  = sts.life_pos ? ST_TK_MUL : ST_PUSH;
            end
            ST_TK_MUL:
            begin
                ctl.tk_mul = 1'b1;
                state_next = ST_TK_POS;
            end
            ST_TK_POS:
            begin
                ctl.tk_pos = 1'b1;
                state_next = ST_TK_WB;
            end
            ST_TK_WB:
            begin
                ctl.tk_wb  = 1'b1;
                state_next = ST_D_DIFF;
            end
            ST_D_DIFF:
            begin
                ctl.d_diff = 1'b1;
                state_next = ST_D_SQ;
            end
            ST_D_SQ:
            begin
                ctl.d_sq   = 1'b1;
                state_next = ST_D_SUM;
            end
            ST_D_SUM:
            begin
                ctl.d_sum  = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                ctl.push = 1'b1;
                if (sts.kind == KIND_SPAWN || sts.idx_end)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    ctl.step   = 1'b1;
                    state_next = ST_TK_SCAN;
                end
            end
            ST_FLUSH:
            begin
                ctl.flush  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    `PPE_ASSERT_IMP(a_push_flush_excl, ctl.push, !ctl.flush, "push and flush together")
    `PPE_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
    `PPE_ASSERT_IMP(a_idle_quiet, !busy, !ctl.push && !ctl.flush, "result command while idle")

endmodule

>>> rtl/ppe_datapath.sv
// Datapath of the particle pool engine: slot stores, flags, arithmetic and result buffer.
`include "particle_pool_engine_macros.svh"
module ppe_datapath
    import ppe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  kind,
    input  logic [15:0]           delta_time,
    input  logic signed [31:0]    vel_x,
    input  logic signed [31:0]    vel_y,
    input  logic signed [31:0]    vel_z,
    input  logic [31:0]           color_rgba,
    input  logic [15:0]           particle_size,
    input  ctl_t                  ctl,
    output sts_t                  sts,
    output logic                  result_valid,
    output logic [SLOT_W-1:0]     slot,
    output logic signed [31:0]    pos_x,
    output logic signed [31:0]    pos_y,
    output logic signed [31:0]    pos_z,
    output logic [15:0]           size_out,
    output logic [31:0]           color_out,
    output logic [63:0]           distance_sq,
    output logic                  alive,
    output logic                  last
);

    logic signed [31:0] cam_reg [3];
    logic signed [31:0] emit_reg [3];
    logic signed [31:0] gravity_reg;
    logic [30:0]        spawn_life_reg;

    logic               kind_reg;
    logic [15:0]        dt_reg;
    logic signed [31:0] vin_reg [3];
    logic [31:0]        color_in_reg;
    logic [15:0]        size_in_reg;

    logic [SLOT_W-1:0]  idx_reg;
    logic [SLOT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0]  last_used_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [POOL_SLOTS-1:0] free_reg;
    logic [POOL_SLOTS-1:0] active_reg;

    logic signed [31:0] gstep_reg;
    logic signed [31:0] p_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [48:0] prod_reg [3];
    logic [31:0]        mag_reg [3];
    logic [63:0]        sq_reg [3];
    logic [63:0]        dist_reg;
    logic [31:0]        color_reg;
    logic [15:0]        size_reg;
    logic               alive_reg;

    logic               hold_valid_reg;
    logic [SLOT_W-1:0]  hold_slot_reg;
    logic signed [31:0] hold_p_reg [3];
    logic [15:0]        hold_size_reg;
    logic [31:0]        hold_color_reg;
    logic [63:0]        hold_dist_reg;
    logic               hold_alive_reg;

    logic               result_valid_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic signed [31:0] out_p_reg [3];
    logic [15:0]        out_size_reg;
    logic [31:0]        out_color_reg;
    logic [63:0]        out_dist_reg;
    logic               out_alive_reg;
    logic               out_last_reg;

    logic [SLOT_W-1:0]  wr_addr;
    logic [SLOT_W-1:0]  idx_inc;
    logic signed [31:0] life_rd;
    logic signed [31:0] life_wdata;
    logic signed [31:0] life_new;
    logic signed [31:0] pos_rd [3];
    logic signed [31:0] vel_rd [3];
    logic [31:0]        color_rd;
    logic [15:0]        size_rd;
    logic signed [16:0] dt_s;
    logic signed [48:0] gprod;
    logic signed [33:0] vy_sum;
    logic signed [31:0] vy_new;
    logic signed [32:0] diff [3];
    logic signed [33:0] pos_sum [3];
    logic [65:0]        dist_sum;
    logic               emit;

    assign wr_addr  = ctl.sp_write ? slot_reg : idx_reg;
    assign idx_inc  = (idx_reg == SLOT_W'(POOL_SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign dt_s     = $signed({1'b0, dt_reg});
    assign gprod    = gravity_reg * dt_s;
    assign life_new = life_rd - $signed({16'd0, dt_reg});
    assign vy_sum   = {{2{vel_rd[1][31]}}, vel_rd[1]} + {{2{gstep_reg[31]}}, gstep_reg};
    assign vy_new   = sat32(vy_sum);
    assign life_wdata = ctl.sp_write ? $signed({1'b0, spawn_life_reg}) : life_new;
    assign dist_sum = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};

    ppe_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_life_ram (
        .clk   (clk),
        .we    (ctl.sp_write || ctl.tk_load),
        .waddr (wr_addr),
        .wdata (life_wdata),
        .raddr (idx_reg),
        .rdata (life_rd)
    );

    ppe_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_color_ram (
        .clk   (clk),
        .we    (ctl.sp_write),
        .waddr (wr_addr),
        .wdata (color_in_reg),
        .raddr (idx_reg),
        .rdata (color_rd)
    );

    ppe_ram #(.WIDTH(16), .DEPTH(POOL_SLOTS)) u_size_ram (
        .clk   (clk),
        .we    (ctl.sp_write),
        .waddr (wr_addr),
        .wdata (size_in_reg),
        .raddr (idx_reg),
        .rdata (size_rd)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_axis
        logic               vel_we;
        logic signed [31:0] pos_wdata;
        logic signed [31:0] vel_wdata;

        assign pos_wdata = ctl.sp_write ? emit_reg[c] : p_reg[c];
        assign vel_wdata = ctl.sp_write ? vin_reg[c] : v_reg[c];
        assign vel_we    = ctl.sp_write || (ctl.tk_wb && c == 1);
        assign diff[c]   = {p_reg[c][31], p_reg[c]} - {cam_reg[c][31], cam_reg[c]};
        assign pos_sum[c] = {{2{p_reg[c][31]}}, p_reg[c]}
                          + {prod_reg[c][48], prod_reg[c][48:16]};

        ppe_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_pos_ram (
            .clk   (clk),
            .we    (ctl.sp_write || ctl.tk_wb),
            .waddr (wr_addr),
            .wdata (pos_wdata),
            .raddr (idx_reg),
            .rdata (pos_rd[c])
        );

        ppe_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_vel_ram (
            .clk   (clk),
            .we    (vel_we),
            .waddr (wr_addr),
            .wdata (vel_wdata),
            .raddr (idx_reg),
            .rdata (vel_rd[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg[0]     <= '0;
            cam_reg[1]     <= '0;
            cam_reg[2]     <= '0;
            emit_reg[0]    <= '0;
            emit_reg[1]    <= '0;
            emit_reg[2]    <= EMITTER_Z_RST;
            gravity_reg    <= GRAVITY_RST;
            spawn_life_reg <= SPAWN_LIFE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CAMERA_X:   cam_reg[0]     <= cfg_data;
                CFG_CAMERA_Y:   cam_reg[1]     <= cfg_data;
                CFG_CAMERA_Z:   cam_reg[2]     <= cfg_data;
                CFG_EMITTER_X:  emit_reg[0]    <= cfg_data;
                CFG_EMITTER_Y:  emit_reg[1]    <= cfg_data;
                CFG_EMITTER_Z:  emit_reg[2]    <= cfg_data;
                CFG_GRAVITY:    gravity_reg    <= cfg_data;
                CFG_SPAWN_LIFE: spawn_life_reg <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg         <= KIND_SPAWN;
            idx_reg          <= '0;
            cnt_reg          <= '0;
            last_used_reg    <= '0;
            slot_reg         <= '0;
            free_reg         <= '1;
            active_reg       <= '0;
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= emit;
            if (ctl.load_in)
            begin
                kind_reg <= kind;
                idx_reg  <= (kind == KIND_TICK) ? '0 : last_used_reg;
                cnt_reg  <= '0;
            end
            if (ctl.step)
            begin
                idx_reg <= idx_inc;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctl.sp_take)
            begin
                if (free_reg[idx_reg])
                begin
                    slot_reg      <= idx_reg;
                    last_used_reg <= idx_reg;
                end
                else
                begin
                    slot_reg <= '0;
                end
            end
            if (ctl.sp_write)
            begin
                free_reg[slot_reg]   <= 1'b0;
                active_reg[slot_reg] <= (spawn_life_reg != '0);
            end
            if (ctl.tk_load)
            begin
                slot_reg            <= idx_reg;
                free_reg[idx_reg]   <= (life_new < 0);
                active_reg[idx_reg] <= (life_new > 0);
            end
            if (ctl.push)
            begin
                hold_valid_reg <= 1'b1;
            end
            if (ctl.flush)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    assign emit = (ctl.push || ctl.flush) && hold_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            dt_reg       <= delta_time;
            vin_reg[0]   <= vel_x;
            vin_reg[1]   <= vel_y;
            vin_reg[2]   <= vel_z;
            color_in_reg <= color_rgba;
            size_in_reg  <= particle_size;
        end
        if (ctl.grav)
        begin
            gstep_reg <= gprod[48:17];
        end
        if (ctl.sp_write)
        begin
            p_reg[0]  <= emit_reg[0];
            p_reg[1]  <= emit_reg[1];
            p_reg[2]  <= emit_reg[2];
            color_reg <= color_in_reg;
            size_reg  <= size_in_reg;
            alive_reg <= (spawn_life_reg != '0);
        end
        if (ctl.tk_load)
        begin
            p_reg[0]  <= pos_rd[0];
            p_reg[1]  <= pos_rd[1];
            p_reg[2]  <= pos_rd[2];
            v_reg[0]  <= vel_rd[0];
            v_reg[1]  <= vy_new;
            v_reg[2]  <= vel_rd[2];
            color_reg <= color_rd;
            size_reg  <= size_rd;
            alive_reg <= (life_new > 0);
            dist_reg  <= '0;
        end
        for (int c = 0; c < 3; c++)
        begin
            if (ctl.tk_mul)
            begin
                prod_reg[c] <= v_reg[c] * dt_s;
            end
            if (ctl.tk_pos)
            begin
                p_reg[c] <= sat32(pos_sum[c]);
            end
            if (ctl.d_diff)
            begin
                mag_reg[c] <= diff[c][32] ? 32'(-diff[c]) : diff[c][31:0];
            end
            if (ctl.d_sq)
            begin
                sq_reg[c] <= mag_reg[c] * mag_reg[c];
            end
        end
        if (ctl.d_sum)
        begin
            dist_reg <= (dist_sum[65:64] != 2'b00) ? '1 : dist_sum[63:0];
        end
        if (emit)
        begin
            out_slot_reg  <= hold_slot_reg;
            out_p_reg[0]  <= hold_p_reg[0];
            out_p_reg[1]  <= hold_p_reg[1];
            out_p_reg[2]  <= hold_p_reg[2];
            out_size_reg  <= hold_size_reg;
            out_color_reg <= hold_color_reg;
            out_dist_reg  <= hold_dist_reg;
            out_alive_reg <= hold_alive_reg;
            out_last_reg  <= ctl.flush;
        end
        if (ctl.push)
        begin
            hold_slot_reg  <= slot_reg;
            hold_p_reg[0]  <= p_reg[0];
            hold_p_reg[1]  <= p_reg[1];
            hold_p_reg[2]  <= p_reg[2];
            hold_size_reg  <= size_reg;
            hold_color_reg <= color_reg;
            hold_dist_reg  <= dist_reg;
            hold_alive_reg <= alive_reg;
        end
    end

    always_comb
    begin
        sts          = '0;
        sts.kind     = kind_reg;
        sts.free_hit = free_reg[idx_reg];
        sts.act_hit  = active_reg[idx_reg];
        sts.scan_end = (cnt_reg == SLOT_W'(POOL_SLOTS - 1));
        sts.idx_end  = (idx_reg == SLOT_W'(POOL_SLOTS - 1));
        sts.life_pos = (life_new > 0);
    end

    assign result_valid = result_valid_reg;
    assign slot         = out_slot_reg;
    assign pos_x        = out_p_reg[0];
    assign pos_y        = out_p_reg[1];
    assign pos_z        = out_p_reg[2];
    assign size_out     = out_size_reg;
    assign color_out    = out_color_reg;
    assign distance_sq  = out_dist_reg;
    assign alive        = out_alive_reg;
    assign last         = out_last_reg;

    `PPE_ASSERT_NXT(a_flush_last, ctl.flush && hold_valid_reg, result_valid && last, "final word not marked last")
    `PPE_ASSERT_NXT(a_last_gap, result_valid && last, !result_valid, "word right after last word")
    `PPE_ASSERT_NXT(a_spawn_taken, ctl.sp_write, !free_reg[$past(slot_reg)], "spawned slot still free")

endmodule
